// File: rtl/svalloc_pkg.sv
// ----------------------------------------------------------------------------
// svalloc_pkg - shared types for the sound voice allocator
// Slot count, result limits, the token that walks the slot chain, the
// broadcast slot load and the result record.
// ----------------------------------------------------------------------------
package svalloc_pkg;

    localparam int SLOTS       = 4;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int HOLD_UNIT   = 6;
    localparam int HCNT_W      = 11;
    localparam int BUSY_W      = 4;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_STOP  = 2'd1,
        ACT_START = 2'd2,
        ACT_DROP  = 2'd3
    } t_action;

    typedef enum logic {
        CMD_PLAY = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    typedef logic [SLOT_W-1:0] t_idx;

    // token handed from cell to cell
    typedef struct packed {
        logic              valid;
        t_cmd              cmd;
        logic [7:0]        snd;
        logic [7:0]        pri;
        logic [7:0]        hold;
        logic [7:0]        vol;
        logic [7:0]        pit;
        logic [BUSY_W-1:0] busy;
        logic              dup;
        logic              free_f;
        t_idx              free_idx;
        logic              act_f;
        t_idx              act_idx;
        logic              pnd_f;
        t_idx              pnd_idx;
    } t_tok;

    // slot load broadcast
    typedef struct packed {
        logic       valid;
        t_idx       idx;
        logic [7:0] snd;
        logic [7:0] pri;
        logic [7:0] hold;
        logic [7:0] vol;
        logic [7:0] pit;
    } t_take;

    typedef struct packed {
        logic       valid;
        t_action    action;
        logic [1:0] slot;
        logic [7:0] snd;
        logic [7:0] vol;
        logic [7:0] pit;
    } t_res;

    typedef struct packed {
        logic       strobe;
        t_action    action;
        logic [1:0] slot;
        logic [7:0] snd;
        logic [7:0] vol;
        logic [7:0] pit;
        logic       last;
    } t_out;

    function automatic logic [1:0] to_slot(input t_idx idx);
        logic [SLOT_W+1:0] ext;
        ext = {2'b00, idx};
        return ext[1:0];
    endfunction

    function automatic logic [HCNT_W-1:0] hold_limit(input logic [7:0] h);
        return HCNT_W'(h) * HCNT_W'(HOLD_UNIT);
    endfunction

endpackage

// File: rtl/svalloc_cell.sv
// ----------------------------------------------------------------------------
// svalloc_cell - one voice slot
// Holds the slot state, folds its slot into the search token of a play
// transaction, runs its tick action and hands the token to the next cell.
// ----------------------------------------------------------------------------
module svalloc_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  svalloc_pkg::t_idx  i_index,
    input  svalloc_pkg::t_tok  i_tok,
    input  svalloc_pkg::t_take i_take,
    output svalloc_pkg::t_tok  o_tok,
    output svalloc_pkg::t_res  o_res
);

    logic                           r_active,  n_active;
    logic                           r_pending, n_pending;
    logic [7:0]                     r_sound,   n_sound;
    logic [7:0]                     r_pri,     n_pri;
    logic [7:0]                     r_hold,    n_hold;
    logic [7:0]                     r_vol,     n_vol;
    logic [7:0]                     r_pit,     n_pit;
    logic [svalloc_pkg::HCNT_W-1:0] r_count,   n_count;
    svalloc_pkg::t_tok              r_tok,     n_tok;
    svalloc_pkg::t_res              res;
    logic                           busy_now;

    assign busy_now = i_tok.busy[0];

    always_comb begin
        n_active  = r_active;
        n_pending = r_pending;
        n_sound   = r_sound;
        n_pri     = r_pri;
        n_hold    = r_hold;
        n_vol     = r_vol;
        n_pit     = r_pit;
        n_count   = r_count;
        n_tok     = i_tok;
        n_tok.busy = i_tok.busy >> 1;
        res       = '0;

        if (i_tok.valid) begin
            unique case (i_tok.cmd)
                svalloc_pkg::CMD_PLAY: begin
                    if (r_pending && r_active && r_sound == i_tok.snd) begin
                        n_tok.dup = 1'b1;
                    end
                    if (!i_tok.free_f && !r_pending && !r_active) begin
                        n_tok.free_f   = 1'b1;
                        n_tok.free_idx = i_index;
                    end
                    if (!i_tok.act_f && !r_pending && r_active && r_pri <= i_tok.pri) begin
                        n_tok.act_f   = 1'b1;
                        n_tok.act_idx = i_index;
                    end
                    if (!i_tok.pnd_f && r_pending && r_active && r_pri < i_tok.pri) begin
                        n_tok.pnd_f   = 1'b1;
                        n_tok.pnd_idx = i_index;
                    end
                end
                svalloc_pkg::CMD_TICK: begin
                    if (r_pending) begin
                        if (r_active && !busy_now) begin
                            res.valid  = 1'b1;
                            res.action = svalloc_pkg::ACT_START;
                            res.slot   = svalloc_pkg::to_slot(i_index);
                            res.snd    = r_sound;
                            res.vol    = r_vol;
                            res.pit    = r_pit;
                            n_pending  = 1'b0;
                        end
                    end else if (r_active) begin
                        if (busy_now) begin
                            if (r_hold != 8'd0) begin
                                if (r_count < svalloc_pkg::hold_limit(r_hold)) begin
                                    n_count = r_count + 1'b1;
                                end else begin
                                    res.valid  = 1'b1;
                                    res.action = svalloc_pkg::ACT_STOP;
                                    res.slot   = svalloc_pkg::to_slot(i_index);
                                    n_active   = 1'b0;
                                end
                            end
                        end else begin
                            n_active = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_take.valid && i_take.idx == i_index) begin
            n_active  = 1'b1;
            n_pending = 1'b1;
            n_sound   = i_take.snd;
            n_pri     = i_take.pri;
            n_hold    = i_take.hold;
            n_vol     = i_take.vol;
            n_pit     = i_take.pit;
            n_count   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_pending <= 1'b0;
            r_count   <= '0;
            r_tok     <= '0;
        end else begin
            r_active  <= n_active;
            r_pending <= n_pending;
            r_count   <= n_count;
            r_tok     <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sound <= n_sound;
        r_pri   <= n_pri;
        r_hold  <= n_hold;
        r_vol   <= n_vol;
        r_pit   <= n_pit;
    end

    assign o_tok = r_tok;
    assign o_res = res;

endmodule

// File: rtl/svalloc_seq.sv
// ----------------------------------------------------------------------------
// svalloc_seq - transaction control and result output
// Tracks busy, picks the slot from the finished search token, issues the
// slot load, and buffers tick results so the final one carries last.
// ----------------------------------------------------------------------------
module svalloc_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  svalloc_pkg::t_tok  i_tok_end,
    input  svalloc_pkg::t_res  i_res [svalloc_pkg::SLOTS],
    output logic               o_busy,
    output svalloc_pkg::t_take o_take,
    output svalloc_pkg::t_out  o_out
);

    logic                          r_busy,   n_busy;
    logic                          r_hold_v, n_hold_v;
    svalloc_pkg::t_res             r_hold,   n_hold;
    logic [svalloc_pkg::CNT_W-1:0] r_cnt,    n_cnt;
    logic                          r_strobe, n_strobe;
    svalloc_pkg::t_out             r_out,    n_out;
    svalloc_pkg::t_res             res;

    always_comb begin
        res = '0;
        for (int k = 0; k < svalloc_pkg::SLOTS; k++) begin
            res = res | i_res[k];
        end
    end

    always_comb begin
        n_busy   = r_busy;
        n_hold_v = r_hold_v;
        n_hold   = r_hold;
        n_cnt    = r_cnt;
        n_strobe = 1'b0;
        n_out    = r_out;
        o_take   = '0;

        if (i_accept) begin
            n_busy = 1'b1;
        end

        if (res.valid && r_cnt < svalloc_pkg::CNT_W'(svalloc_pkg::MAX_RESULTS)) begin
            if (r_hold_v) begin
                n_strobe     = 1'b1;
                n_out.action = r_hold.action;
                n_out.slot   = r_hold.slot;
                n_out.snd    = r_hold.snd;
                n_out.vol    = r_hold.vol;
                n_out.pit    = r_hold.pit;
                n_out.last   = 1'b0;
            end
            n_hold_v = 1'b1;
            n_hold   = res;
            n_cnt    = r_cnt + 1'b1;
        end

        if (i_tok_end.valid) begin
            n_busy     = 1'b0;
            n_strobe   = 1'b1;
            n_out.last = 1'b0;
            n_out.slot = 2'd0;
            n_out.snd  = 8'd0;
            n_out.vol  = 8'd0;
            n_out.pit  = 8'd0;
            n_out.last = 1'b1;
            unique case (i_tok_end.cmd)
                svalloc_pkg::CMD_TICK: begin
                    if (r_hold_v) begin
                        n_out.action = r_hold.action;
                        n_out.slot   = r_hold.slot;
                        n_out.snd    = r_hold.snd;
                        n_out.vol    = r_hold.vol;
                        n_out.pit    = r_hold.pit;
                    end else begin
                        n_out.action = svalloc_pkg::ACT_NONE;
                    end
                    n_hold_v = 1'b0;
                    n_cnt    = '0;
                end
                svalloc_pkg::CMD_PLAY: begin
                    o_take.snd  = i_tok_end.snd;
                    o_take.pri  = i_tok_end.pri;
                    o_take.hold = i_tok_end.hold;
                    o_take.vol  = i_tok_end.vol;
                    o_take.pit  = i_tok_end.pit;
                    priority if (i_tok_end.dup) begin
                        o_take.valid = 1'b0;
                    end else if (i_tok_end.free_f) begin
                        o_take.valid = 1'b1;
                        o_take.idx   = i_tok_end.free_idx;
                    end else if (i_tok_end.act_f) begin
                        o_take.valid = 1'b1;
                        o_take.idx   = i_tok_end.act_idx;
                    end else if (i_tok_end.pnd_f) begin
                        o_take.valid = 1'b1;
                        o_take.idx   = i_tok_end.pnd_idx;
                    end else begin
                        o_take.valid = 1'b0;
                    end
                    if (o_take.valid) begin
                        n_out.action = svalloc_pkg::ACT_STOP;
                        n_out.slot   = svalloc_pkg::to_slot(o_take.idx);
                    end else begin
                        n_out.action = svalloc_pkg::ACT_DROP;
                    end
                end
                default: begin
                end
            endcase
        end
        n_out.strobe = n_strobe;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_hold_v <= 1'b0;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_hold_v <= n_hold_v;
            r_cnt    <= n_cnt;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
        r_out  <= n_out;
    end

    assign o_busy = r_busy;

    always_comb begin
        o_out        = r_out;
        o_out.strobe = r_strobe;
    end

endmodule

// File: rtl/sound_voice_allocator_unit.sv
// ----------------------------------------------------------------------------
// sound_voice_allocator_unit - sound effect voice allocator
// Priority based slot allocation with stealing, built as a chain of slot
// cells walked by a token, one cell per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken on a rising edge with start high and busy low.
//   i_command selects a play request or a tick carrying i_channel_busy.
//   Results appear on the o_ ports for one cycle each, flagged by
//   o_strobe; o_last marks the final result of the transaction.
//   A play request gives one result (stop on the taken slot, or dropped).
//   A tick gives one result per acting slot, or a single none result.
// Flow:
//   The token crosses the cell chain through the register of each cell in
//   turn, and the final result is registered again in svalloc_seq. Busy
//   drops on the edge where the final result appears, so a new transaction
//   is taken only after the previous one has ended. Earlier tick results
//   come out while the token is still moving.
// Reset:
//   Synchronous, active low; all slots go inactive and not pending.
//   The receiver cannot stall: every strobed result is taken.
// ----------------------------------------------------------------------------
module sound_voice_allocator_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_command,
    input  logic [7:0] i_sound_number,
    input  logic [7:0] i_priority_req,
    input  logic [7:0] i_hold_ticks,
    input  logic [7:0] i_volume,
    input  logic [7:0] i_pitch_offset,
    input  logic [3:0] i_channel_busy,
    output logic       o_strobe,
    output logic [1:0] o_action,
    output logic [1:0] o_slot,
    output logic [7:0] o_out_sound,
    output logic [7:0] o_out_volume,
    output logic [7:0] o_out_pitch,
    output logic       o_last
);

    svalloc_pkg::t_tok  tok [svalloc_pkg::SLOTS+1];
    svalloc_pkg::t_res  res [svalloc_pkg::SLOTS];
    svalloc_pkg::t_take take;
    svalloc_pkg::t_out  out_rec;
    logic               accept;

    assign accept = start && !busy;

    always_comb begin
        tok[0]       = '0;
        tok[0].valid = accept;
        tok[0].cmd   = svalloc_pkg::t_cmd'(i_command);
        tok[0].snd   = i_sound_number;
        tok[0].pri   = i_priority_req;
        tok[0].hold  = i_hold_ticks;
        tok[0].vol   = i_volume;
        tok[0].pit   = i_pitch_offset;
        tok[0].busy  = i_channel_busy;
    end

    for (genvar g = 0; g < svalloc_pkg::SLOTS; g++) begin : g_cell
        svalloc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (svalloc_pkg::SLOT_W'(g)),
            .i_tok   (tok[g]),
            .i_take  (take),
            .o_tok   (tok[g+1]),
            .o_res   (res[g])
        );
    end

    svalloc_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_tok_end (tok[svalloc_pkg::SLOTS]),
        .i_res     (res),
        .o_busy    (busy),
        .o_take    (take),
        .o_out     (out_rec)
    );

    assign o_strobe     = out_rec.strobe;
    assign o_action     = out_rec.action;
    assign o_slot       = out_rec.slot;
    assign o_out_sound  = out_rec.snd;
    assign o_out_volume = out_rec.vol;
    assign o_out_pitch  = out_rec.pit;
    assign o_last       = out_rec.last;

endmodule

// File: rtl/svalloc_checker.sv
// ----------------------------------------------------------------------------
// svalloc_checker - port level checks for the voice allocator
// Watches busy, start and the result ports over time; bound to the top.
// ----------------------------------------------------------------------------
module svalloc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_strobe,
    input logic [1:0] o_action,
    input logic [1:0] o_slot,
    input logic [7:0] o_out_sound,
    input logic [7:0] o_out_volume,
    input logic [7:0] o_out_pitch,
    input logic       o_last
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted transaction");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> !busy)
        else $error("final result shown while still busy");

    a_busy_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe && o_last)
        else $error("busy dropped without a final result");

    a_drop_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_action == svalloc_pkg::ACT_DROP |-> o_last && o_slot == 2'd0)
        else $error("dropped result malformed");

    a_payload_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_action != svalloc_pkg::ACT_START |->
            o_out_sound == 8'd0 && o_out_volume == 8'd0 && o_out_pitch == 8'd0)
        else $error("payload not cleared on non-start result");

endmodule

bind sound_voice_allocator_unit svalloc_checker u_svalloc_checker (.*);
